### rtl/htp_pkg.sv
// Shared types, codes and field widths of the triangular-probe hash table.
package htp_pkg;

	localparam int KEY_W     = 31;
	localparam int PAYLOAD_W = 32;
	localparam int SLOT_W    = 4;
	localparam int STATUS_W  = 3;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd4;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
		logic [SLOT_W-1:0]    slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot_out;
		logic [KEY_W-1:0]     key_out;
		logic [PAYLOAD_W-1:0] payload_out;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_HASH,
		S_PROBE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic decode;
		logic walk_start;
		logic probe;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic dec_finish;
		logic dec_remove;
		logic hash_done;
		logic probe_finish;
	} sts_t;

endpackage

### rtl/htp_stream_if.sv
// Valid/ready stream interface carrying one payload word per transfer.
interface htp_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/htp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/htp_hash.sv
// Home-slot unit: key modulo SLOTS, a mask for powers of two, else a reciprocal multiply.
module htp_hash #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [htp_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output logic [$clog2(SLOTS)-1:0]    rem
);
	localparam int IDX_W = $clog2(SLOTS);

	if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
		logic             done_q;
		logic [IDX_W-1:0] rem_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= key[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign rem  = rem_q;
	end else begin : g_recip
		// quotient estimate from a fixed reciprocal is low by at most one,
		// so a single compare and subtract gives the remainder
		localparam int SH  = htp_pkg::KEY_W + IDX_W;
		localparam int PW  = htp_pkg::KEY_W + 32;
		localparam int QW  = PW - SH;
		localparam int KW1 = htp_pkg::KEY_W + 1;
		localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(SLOTS));

		logic                      vld_s1;
		logic                      done_q;
		logic [PW-1:0]             prod_s1;
		logic [htp_pkg::KEY_W-1:0] key_s1;
		logic [IDX_W-1:0]          rem_q;
		logic [QW-1:0]             quo;
		logic [KW1-1:0]            diff;
		logic [KW1-1:0]            rem_full;

		always_comb begin
			quo      = prod_s1[PW-1:SH];
			diff     = {1'b0, key_s1} - KW1'(quo) * KW1'(SLOTS);
			rem_full = (diff >= KW1'(SLOTS)) ? diff - KW1'(SLOTS) : diff;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				done_q <= 1'b0;
			end else begin
				vld_s1 <= start;
				done_q <= vld_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				prod_s1 <= PW'(key) * PW'(RECIP);
				key_s1  <= key;
			end
			if (vld_s1) begin
				rem_q <= rem_full[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign rem  = rem_q;
	end
endmodule

### rtl/htp_datapath.sv
// Datapath: request register, probe walk, key/payload stores and result registers.
module htp_datapath #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  htp_pkg::req_t in_data,
	input  htp_pkg::cmd_t cmd,
	output htp_pkg::sts_t sts,
	output htp_pkg::rsp_t out_data
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SW    = (CNT_W > htp_pkg::SLOT_W) ? CNT_W : htp_pkg::SLOT_W;

	htp_pkg::req_t req_q;
	htp_pkg::rsp_t res_q;
	htp_pkg::rsp_t out_q;
	htp_pkg::rsp_t res_dec;
	htp_pkg::rsp_t res_cmp;

	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] addr_s1;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] home;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] addr_next;
	logic [IDX_W:0]   addr_sum;
	logic [CNT_W-1:0] i_q;
	logic             more_q;
	logic             valid_s1;
	logic             last_s1;

	logic bad_req;
	logic rem_req;
	logic slot_ok;
	logic dec_fin;
	logic hash_start;
	logic hash_done;

	logic                      key_empty;
	logic                      key_hit;
	logic                      fin_cmp;
	logic                      key_we_cmp;
	logic [htp_pkg::KEY_W-1:0] key_wd_cmp;
	logic                      pay_we;

	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	logic                      key_we;
	logic [IDX_W-1:0]          key_waddr;
	logic [htp_pkg::KEY_W-1:0] key_wdata;
	logic [htp_pkg::KEY_W-1:0] key_rd;
	logic [PAYLOAD_BITS-1:0]   pay_rd;

	// decode of the registered request
	always_comb begin
		rem_req = (req_q.req_type == htp_pkg::REQ_REMOVE);
		bad_req = (req_q.req_type != htp_pkg::REQ_INSERT &&
			req_q.req_type != htp_pkg::REQ_SEARCH && !rem_req) ||
			(!rem_req && req_q.key == '0);
		slot_ok  = SW'(req_q.slot) < SW'(SLOTS);
		slot_idx = IDX_W'(req_q.slot);
		dec_fin  = bad_req || (rem_req && !slot_ok);
		if (bad_req) begin
			res_dec = '{status: htp_pkg::ST_BAD_KEY, slot_out: '0, key_out: '0,
				payload_out: '0};
		end else begin
			res_dec = '{status: htp_pkg::ST_EMPTY, slot_out: req_q.slot, key_out: '0,
				payload_out: '0};
		end
	end

	assign hash_start = cmd.decode && !dec_fin && !rem_req;

	htp_hash #(
		.SLOTS (SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req_q.key),
		.done   (hash_done),
		.rem    (home)
	);

	// next triangular step: previous slot plus probe number, one wrap at most
	always_comb begin
		addr_sum  = (IDX_W+1)'(addr_q) + (IDX_W+1)'(i_q) + (IDX_W+1)'(1);
		addr_next = (addr_sum >= (IDX_W+1)'(SLOTS)) ?
			IDX_W'(addr_sum - (IDX_W+1)'(SLOTS)) : IDX_W'(addr_sum);
	end

	// compare stage on the registered read data
	always_comb begin
		key_empty  = (key_rd == '0);
		key_hit    = (key_rd == req_q.key);
		fin_cmp    = 1'b0;
		res_cmp    = '0;
		key_we_cmp = 1'b0;
		key_wd_cmp = '0;
		pay_we     = 1'b0;
		if (valid_s1) begin
			case (req_q.req_type)
				htp_pkg::REQ_INSERT: begin
					if (key_empty) begin
						fin_cmp    = 1'b1;
						key_we_cmp = 1'b1;
						key_wd_cmp = req_q.key;
						pay_we     = 1'b1;
						res_cmp    = '{status: htp_pkg::ST_OK,
							slot_out: htp_pkg::SLOT_W'(addr_s1), key_out: req_q.key,
							payload_out: '0};
					end else if (last_s1) begin
						fin_cmp = 1'b1;
						res_cmp = '{status: htp_pkg::ST_FULL, slot_out: '0, key_out: '0,
							payload_out: '0};
					end
				end
				htp_pkg::REQ_SEARCH: begin
					if (key_empty || (!key_hit && last_s1)) begin
						fin_cmp = 1'b1;
						res_cmp = '{status: htp_pkg::ST_NOT_FOUND, slot_out: '0,
							key_out: '0, payload_out: '0};
					end else if (key_hit) begin
						fin_cmp = 1'b1;
						res_cmp = '{status: htp_pkg::ST_OK,
							slot_out: htp_pkg::SLOT_W'(addr_s1), key_out: req_q.key,
							payload_out: htp_pkg::PAYLOAD_W'(pay_rd)};
					end
				end
				htp_pkg::REQ_REMOVE: begin
					fin_cmp = 1'b1;
					if (key_empty) begin
						res_cmp = '{status: htp_pkg::ST_EMPTY, slot_out: req_q.slot,
							key_out: '0, payload_out: '0};
					end else begin
						key_we_cmp = 1'b1;
						res_cmp    = '{status: htp_pkg::ST_OK, slot_out: req_q.slot,
							key_out: key_rd, payload_out: '0};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// store ports
	always_comb begin
		rd_en     = (cmd.decode && rem_req && slot_ok) || (cmd.probe && more_q);
		rd_addr   = cmd.decode ? slot_idx : addr_q;
		key_we    = cmd.clear_step || key_we_cmp;
		key_waddr = cmd.clear_step ? clr_q : addr_s1;
		key_wdata = cmd.clear_step ? '0 : key_wd_cmp;
	end

	htp_ram #(
		.WIDTH (htp_pkg::KEY_W),
		.DEPTH (SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	htp_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (SLOTS)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (addr_s1),
		.wdata (PAYLOAD_BITS'(req_q.payload)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			more_q   <= 1'b0;
			clr_q    <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.decode) begin
				valid_s1 <= rem_req && slot_ok;
				more_q   <= 1'b0;
			end else if (cmd.walk_start) begin
				valid_s1 <= 1'b0;
				more_q   <= 1'b1;
			end else if (cmd.probe) begin
				if (fin_cmp) begin
					valid_s1 <= 1'b0;
					more_q   <= 1'b0;
				end else begin
					valid_s1 <= more_q;
					if (more_q) begin
						more_q <= (i_q != CNT_W'(SLOTS - 1));
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.decode) begin
			addr_s1 <= slot_idx;
			last_s1 <= 1'b1;
			if (dec_fin) begin
				res_q <= res_dec;
			end
		end
		if (cmd.walk_start) begin
			addr_q <= home;
			i_q    <= '0;
		end
		if (cmd.probe) begin
			if (more_q) begin
				addr_s1 <= addr_q;
				last_s1 <= (i_q == CNT_W'(SLOTS - 1));
				i_q     <= i_q + CNT_W'(1);
				addr_q  <= addr_next;
			end
			if (fin_cmp) begin
				res_q <= res_cmp;
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		sts.clear_done   = (clr_q == IDX_W'(SLOTS - 1));
		sts.dec_finish   = dec_fin;
		sts.dec_remove   = rem_req;
		sts.hash_done    = hash_done;
		sts.probe_finish = fin_cmp;
	end

	assign out_data = out_q;
endmodule

### rtl/htp_ctrl.sv
// Controller: sequences clearing, decode, hashing, probe walk and result hand-off.
module htp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  htp_pkg::sts_t sts,
	output htp_pkg::cmd_t cmd
);
	htp_pkg::state_t state_q;
	htp_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htp_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			htp_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_d = htp_pkg::S_IDLE;
				end
			end
			htp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = htp_pkg::S_DECODE;
				end
			end
			htp_pkg::S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.dec_finish) begin
					state_d = htp_pkg::S_DONE;
				end else if (sts.dec_remove) begin
					state_d = htp_pkg::S_PROBE;
				end else begin
					state_d = htp_pkg::S_HASH;
				end
			end
			htp_pkg::S_HASH: begin
				if (sts.hash_done) begin
					cmd.walk_start = 1'b1;
					state_d        = htp_pkg::S_PROBE;
				end
			end
			htp_pkg::S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.probe_finish) begin
					state_d = htp_pkg::S_DONE;
				end
			end
			htp_pkg::S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = htp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = htp_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

### rtl/hash_table_triangular_probe_unit.sv
// Top level: open-addressing hash table with triangular probing, one request at a time.
// Inserts and searches take longer the more probes they need; when SLOTS is not a power of two
// the home-slot remainder follows a registered reciprocal product. Removes skip hashing, and a
// rejected request goes straight to DONE. A new request is taken once the result is loaded.
// Probes run one per cycle through the key store's registered read port, at most SLOTS a walk.
// Reset: asynchronous; afterwards the key store is cleared slot by slot, no request is taken then.
module hash_table_triangular_probe_unit #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	htp_stream_if.sink   req,
	htp_stream_if.source rsp
);
	// Flow of one request:
	//   IDLE   - request transfer accepted and registered
	//   DECODE - reject zero key / unknown type, check the remove slot,
	//            start the home-slot unit or read the slot to be removed
	//   HASH   - wait for key mod SLOTS
	//   PROBE  - issue one store read per cycle; the compare stage checks the
	//            registered read data and stops the walk on empty, match or
	//            the last probe. Reads issued past the stop are dropped.
	//   DONE   - move the result into the output register once it is free
	// The output register holds a result while the next request is accepted.

	htp_pkg::cmd_t cmd;
	htp_pkg::sts_t sts;

	htp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Key store clears after reset; payload store is never cleared since a
	// payload is only read back on a search hit, after its insert.
	htp_datapath #(
		.SLOTS        (SLOTS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (rsp.data)
	);
endmodule

### rtl/htp_checker.sv
// Port-level checks of the hash table unit, bound to the top level.
module htp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input htp_pkg::rsp_t out_data
);
	logic [1:0] pend_q;

	// requests accepted whose result has not yet been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown with no request outstanding");

	a_ok_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == htp_pkg::ST_OK |-> out_data.key_out != '0)
		else $error("successful result carries an empty key");

	a_fail_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != htp_pkg::ST_OK |-> out_data.payload_out == '0)
		else $error("failed result carries a payload");
endmodule

bind hash_table_triangular_probe_unit htp_checker u_htp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);

### dv/htp_table_sb_pkg.sv
// Scoreboard class for the probe table: shadow table, expected responses and field checks.
package htp_table_sb_pkg;
	import htp_pkg::*;

	localparam int TABLE_SLOTS = 16;

	class table_scoreboard;
		logic [KEY_W-1:0]     key_copy[TABLE_SLOTS];
		logic [PAYLOAD_W-1:0] data_copy[TABLE_SLOTS];
		rsp_t                 due_rsp[$];
		int                   errors;
		int                   checked;

		function new();
			foreach (key_copy[s]) begin
				key_copy[s]  = '0;
				data_copy[s] = '0;
			end
			errors  = 0;
			checked = 0;
		endfunction

		function int pending();
			return due_rsp.size();
		endfunction

		function int occupancy();
			int n;
			n = 0;
			foreach (key_copy[s])
				if (key_copy[s] != '0)
					n++;
			return n;
		endfunction

		// Apply one accepted request to the shadow table and queue its response.
		function void note_request(req_t r);
			rsp_t e;
			int   pos;
			int   i;
			bit   stopped;
			e = '0;
			if (r.req_type == REQ_REMOVE) begin
				e.slot_out = r.slot;
				if (int'(r.slot) >= TABLE_SLOTS || key_copy[r.slot] == '0) begin
					e.status = ST_EMPTY;
				end else begin
					e.status  = ST_OK;
					e.key_out = key_copy[r.slot];
					key_copy[r.slot] = '0;
				end
			end else if ((r.req_type != REQ_INSERT && r.req_type != REQ_SEARCH) || r.key == '0) begin
				e.status = ST_BAD_KEY;
			end else begin
				e.status = (r.req_type == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
				pos      = int'(r.key % TABLE_SLOTS);
				stopped  = 1'b0;
				// triangular walk: each step moves one further than the last
				for (i = 0; i < TABLE_SLOTS && !stopped; i++) begin
					pos = (pos + i) % TABLE_SLOTS;
					if (key_copy[pos] == '0) begin
						stopped = 1'b1;
						if (r.req_type == REQ_INSERT) begin
							key_copy[pos]  = r.key;
							data_copy[pos] = r.payload;
							e.status   = ST_OK;
							e.slot_out = SLOT_W'(pos);
							e.key_out  = r.key;
						end
					end else if (r.req_type == REQ_SEARCH && key_copy[pos] == r.key) begin
						stopped       = 1'b1;
						e.status      = ST_OK;
						e.slot_out    = SLOT_W'(pos);
						e.key_out     = r.key;
						e.payload_out = data_copy[pos];
					end
				end
			end
			due_rsp.push_back(e);
		endfunction

		task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
			errors++;
			$display("[%0t] response %0d %s: got %0h want %0h", $time, checked, what, got_v,
				want_v);
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			checked++;
			if (due_rsp.size() == 0) begin
				report_mismatch("arrived with none outstanding, status", got.status, '0);
			end else begin
				want = due_rsp.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.slot_out !== want.slot_out)
					report_mismatch("slot_out", got.slot_out, want.slot_out);
				if (got.key_out !== want.key_out)
					report_mismatch("key_out", got.key_out, want.key_out);
				if (got.payload_out !== want.payload_out)
					report_mismatch("payload_out", got.payload_out, want.payload_out);
			end
		endtask
	endclass

endpackage

### dv/tb_hash_table_triangular_probe_unit.sv
// Testbench top: drives random and directed table requests and checks every response.
module tb_hash_table_triangular_probe_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import htp_pkg::*;
	import htp_table_sb_pkg::*;

	// req_type 3 has no name in the package; the block must reject it
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int POOL_N = 24;
	localparam int PHASE_ITEMS = 630;

	logic clk;
	logic arst_n;

	htp_stream_if #(.data_t(req_t)) req_ch ();
	htp_stream_if #(.data_t(rsp_t)) rsp_ch ();

	hash_table_triangular_probe_unit #(
		.SLOTS       (TABLE_SLOTS),
		.PAYLOAD_BITS(PAYLOAD_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	table_scoreboard sb = new();

	// idle rates in percent per cycle; rx_hold counts down a forced receiver stall
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	// operation mix for random requests, in percent
	int ins_pct;
	int rem_pct;
	logic [KEY_W-1:0] key_pool[POOL_N];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: random back-pressure, or a solid hold-off while rx_hold runs down.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Response monitor: every output transfer goes to the scoreboard.
	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.data);

	function automatic req_t mk(logic [1:0] t, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p,
		logic [SLOT_W-1:0] s);
		req_t r;
		r.req_type = t;
		r.key      = k;
		r.payload  = p;
		r.slot     = s;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] any_key();
		logic [KEY_W-1:0] k;
		do
			k = KEY_W'($urandom());
		while (k == '0);
		return k;
	endfunction

	// Random request. Keys mostly come from a small pool with clustered home slots so
	// searches hit and walks grow long; removes mostly target live slots.
	function automatic req_t gen_request();
		req_t r;
		int   pick;
		int   live[$];
		r = mk(REQ_SEARCH, key_pool[$urandom_range(POOL_N-1)], PAYLOAD_W'($urandom()),
			SLOT_W'($urandom_range(TABLE_SLOTS-1)));
		pick = $urandom_range(99);
		if (pick < 4) begin
			// junk: unknown request or a zero key
			if (pick < 2) begin
				r.req_type = REQ_UNKNOWN;
				r.key      = KEY_W'($urandom());
			end else begin
				r.req_type = pick[0] ? REQ_INSERT : REQ_SEARCH;
				r.key      = '0;
			end
		end else if (pick < 4 + ins_pct) begin
			r.req_type = REQ_INSERT;
			if ($urandom_range(99) < 25)
				r.key = any_key();
		end else if (pick < 4 + ins_pct + rem_pct) begin
			r.req_type = REQ_REMOVE;
			foreach (sb.key_copy[s])
				if (sb.key_copy[s] != '0)
					live.push_back(s);
			if (live.size() != 0 && $urandom_range(99) < 85)
				r.slot = SLOT_W'(live[$urandom_range(live.size()-1)]);
		end else if ($urandom_range(99) < 20) begin
			r.key = any_key();
		end
		return r;
	endfunction

	// Offer one request, idling first at the sender's rate, and hold it until the transfer.
	task automatic offer(req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(r);
	endtask

	// Sender stands back until every outstanding response has been taken.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		tx_idle_pct  = 12;
		rx_idle_pct  = 62;
		rx_hold      = 0;
		ins_pct      = 60;
		rem_pct      = 15;
		// first two thirds of the pool share home slots 0..3
		foreach (key_pool[i]) begin
			key_pool[i] = any_key();
			if (i < 16)
				key_pool[i][3:0] = 4'($urandom_range(3));
			if (key_pool[i] == '0)
				key_pool[i] = 31'h10;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// zero keys and the unknown request are rejected outright
		offer(mk(REQ_INSERT, '0, '1, '0));
		offer(mk(REQ_SEARCH, '0, '0, '1));
		offer(mk(REQ_UNKNOWN, '1, '1, '1));
		// remove of an empty slot, search of an empty table
		offer(mk(REQ_REMOVE, '0, '0, 4'd15));
		offer(mk(REQ_SEARCH, 31'd5, '0, '0));
		// extremes of key and payload, then a cluster on home slot 1
		offer(mk(REQ_INSERT, 31'd1, '1, '0));
		offer(mk(REQ_INSERT, 31'h7FFF_FFFF, '0, '0));
		offer(mk(REQ_INSERT, 31'd17, 32'h5A5A_5A5A, '0));
		offer(mk(REQ_INSERT, 31'd33, 32'hA5A5_A5A5, '0));
		offer(mk(REQ_INSERT, 31'd1, 32'h1234_5678, '0));    // duplicate key
		offer(mk(REQ_SEARCH, 31'd33, '0, '0));
		offer(mk(REQ_SEARCH, 31'd49, '0, '0));              // walk ends on an empty slot
		offer(mk(REQ_REMOVE, '0, '0, 4'd1));
		offer(mk(REQ_SEARCH, 31'd17, '0, '0));              // chain now broken at home
		offer(mk(REQ_SEARCH, 31'h7FFF_FFFF, '0, '1));
		// fill to the brim, then a full insert and a search that runs out of probes
		while (sb.occupancy() < TABLE_SLOTS)
			offer(mk(REQ_INSERT, any_key(), PAYLOAD_W'($urandom()), '0));
		offer(mk(REQ_INSERT, 31'h2AAA_AAAA, '1, '0));
		offer(mk(REQ_SEARCH, 31'h5555_5555, '0, '0));
		wait_drained();

		// --- random part: three idle profiles, mix swinging between fill and drain ---
		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 62 : 0;
			rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 12 : 0;
			// long receiver hold-off while the sender keeps offering
			if (ph != 1)
				rx_hold = 300;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 45 == 0) begin
					ins_pct = ((n / 45) % 2 == 0) ? 60 : 20;
					rem_pct = ((n / 45) % 2 == 0) ? 15 : 40;
				end
				offer(gen_request());
				if (n % 200 == 199)
					wait_drained();
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
rtl/htp_pkg.sv
rtl/htp_stream_if.sv
rtl/htp_ram.sv
rtl/htp_hash.sv
rtl/htp_datapath.sv
rtl/htp_ctrl.sv
rtl/hash_table_triangular_probe_unit.sv
rtl/htp_checker.sv
dv/htp_table_sb_pkg.sv
dv/tb_hash_table_triangular_probe_unit.sv
